// File: design/npcm_pkg.sv
// Shared types, palette tables and distance function for the palette matcher.
package npcm_pkg;

    localparam int PAL_SIZE    = 16;
    localparam int IDX_W       = 4;
    localparam int SUM_W       = 18;
    localparam int DIST_W      = 9;
    localparam int SQRT_STEPS  = 9;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 40;

    localparam logic SEL_YUV = 1'b0;
    localparam logic SEL_RGB = 1'b1;

    // Entry packing: [23:16] first channel, [15:8] second, [7:0] third.
    localparam logic [23:0] RGB_PAL [PAL_SIZE] = '{
        24'h000000, 24'hFFFFFF, 24'h3A6616, 24'hACA65D,
        24'h814884, 24'hA47266, 24'h403286, 24'hBFB7E9,
        24'h6350A5, 24'h504400, 24'h699646, 24'h505050,
        24'h787878, 24'hE4B2A6, 24'h786ABD, 24'h9F9F9F
    };

    localparam logic [23:0] YUV_PAL [PAL_SIZE] = '{
        24'h000000, 24'hFF0000, 24'h500000, 24'h9F000B,
        24'h60121D, 24'h800020, 24'h402200, 24'hBF1500,
        24'h602203, 24'h40000E, 24'h800000, 24'h500000,
        24'h780000, 24'hBF0020, 24'h782200, 24'h9F0000
    };

    typedef struct packed {
        logic       sel;
        logic [7:0] ch_a;
        logic [7:0] ch_b;
        logic [7:0] ch_c;
    } pix_t;

    typedef struct packed {
        logic             valid;
        pix_t             pix;
        logic [SUM_W-1:0] min_sum;
    } min_tok_t;

    typedef struct packed {
        logic             valid;
        pix_t             pix;
        logic [SUM_W-1:0] rem;
        logic [SUM_W-1:0] root;
    } sqrt_tok_t;

    typedef struct packed {
        logic              valid;
        pix_t              pix;
        logic [SUM_W-1:0]  bound;
        logic [DIST_W-1:0] distance;
        logic              found;
        logic [IDX_W-1:0]  idx;
    } pick_tok_t;

    function automatic logic [15:0] sq_diff(input logic [7:0] x, input logic [7:0] y);
        logic [7:0]  d;
        logic [15:0] w;
        d = (x > y) ? (x - y) : (y - x);
        w = {8'h00, d};
        return w * w;
    endfunction

    // Squared Euclidean distance from a pixel to one entry of the selected table.
    function automatic logic [SUM_W-1:0] dist_sq(input pix_t p, input logic [IDX_W-1:0] k);
        logic [23:0] ent;
        ent = (p.sel == SEL_RGB) ? RGB_PAL[k] : YUV_PAL[k];
        return SUM_W'(sq_diff(ent[23:16], p.ch_a)) + SUM_W'(sq_diff(ent[15:8], p.ch_b))
             + SUM_W'(sq_diff(ent[7:0], p.ch_c));
    endfunction

endpackage

// File: design/nearest_palette_color_match.sv
// Stages: 16 min cells, 9 sqrt steps, 1 bound register, 16 pick cells, then the output register.
// Throughput: one pixel per cycle while the skid register is empty; all stages advance together.
// Backpressure: output register plus skid register; s_axis_tready is registered.
// Reset: rst_n async active low clears all valid flags; table_select resets to 1 (RGB table).
module nearest_palette_color_match
    import npcm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // channel_a, channel_b, channel_c
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // palette_index, distance, color_first,
                                                  // color_second, color_third, 3'b0 pad
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_data        // table_select
);

    logic                  table_select_reg;
    logic                  en;
    min_tok_t              min_tok  [PAL_SIZE+1];
    sqrt_tok_t             sqrt_tok [SQRT_STEPS+1];
    pick_tok_t             pick_tok [PAL_SIZE+1];
    pick_tok_t             bound_reg;
    logic [SUM_W-1:0]      root_inc;
    logic [OUT_DATA_W-1:0] pipe_data;
    logic                  pipe_valid;
    logic [23:0]           color;
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  skid_valid_reg;
    logic [OUT_DATA_W-1:0] skid_data_reg;
    logic                  take;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_select_reg <= SEL_RGB;
        end
        else if (cfg_valid)
        begin
            table_select_reg <= cfg_data;
        end
    end

    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;

    assign min_tok[0] = '{valid:   s_axis_tvalid,
                          pix:     '{sel:  table_select_reg,
                                     ch_a: s_axis_tdata[7:0],
                                     ch_b: s_axis_tdata[15:8],
                                     ch_c: s_axis_tdata[23:16]},
                          min_sum: '1};

    for (genvar k = 0; k < PAL_SIZE; k++)
    begin : g_min
        npcm_min_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .entry_idx (IDX_W'(k)),
            .tok_in    (min_tok[k]),
            .tok_out   (min_tok[k+1])
        );
    end

    assign sqrt_tok[0] = '{valid: min_tok[PAL_SIZE].valid,
                           pix:   min_tok[PAL_SIZE].pix,
                           rem:   min_tok[PAL_SIZE].min_sum,
                           root:  '0};

    for (genvar i = 0; i < SQRT_STEPS; i++)
    begin : g_sqrt
        npcm_sqrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .step_bit (SUM_W'(1) << (2 * (SQRT_STEPS - 1 - i))),
            .tok_in   (sqrt_tok[i]),
            .tok_out  (sqrt_tok[i+1])
        );
    end

    assign root_inc = SUM_W'(sqrt_tok[SQRT_STEPS].root[DIST_W-1:0]) + SUM_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bound_reg <= '0;
        end
        else if (en)
        begin
            bound_reg.valid    <= sqrt_tok[SQRT_STEPS].valid;
            bound_reg.pix      <= sqrt_tok[SQRT_STEPS].pix;
            bound_reg.bound    <= root_inc * root_inc;
            bound_reg.distance <= sqrt_tok[SQRT_STEPS].root[DIST_W-1:0];
            bound_reg.found    <= 1'b0;
            bound_reg.idx      <= '0;
        end
    end

    assign pick_tok[0] = bound_reg;

    for (genvar k = 0; k < PAL_SIZE; k++)
    begin : g_pick
        npcm_pick_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .entry_idx (IDX_W'(k)),
            .tok_in    (pick_tok[k]),
            .tok_out   (pick_tok[k+1])
        );
    end

    assign color      = RGB_PAL[pick_tok[PAL_SIZE].idx];
    assign pipe_data  = {3'b000, color[7:0], color[15:8], color[23:16],
                         pick_tok[PAL_SIZE].distance, pick_tok[PAL_SIZE].idx};
    assign pipe_valid = pick_tok[PAL_SIZE].valid && en;
    assign take       = out_valid_reg && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= pipe_valid;
            end
        end
        else if (pipe_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || take)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : pipe_data;
        end
        else if (pipe_valid)
        begin
            skid_data_reg <= pipe_data;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// File: design/npcm_min_cell.sv
// One palette entry of the minimum-distance chain: keeps the smaller squared distance.
module npcm_min_cell
    import npcm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic [IDX_W-1:0] entry_idx,
    input  min_tok_t         tok_in,
    output min_tok_t         tok_out
);

    min_tok_t         tok_reg;
    min_tok_t         tok_next;
    logic [SUM_W-1:0] sum;

    always_comb
    begin
        sum      = dist_sq(tok_in.pix, entry_idx);
        tok_next = tok_in;
        if (sum < tok_in.min_sum)
        begin
            tok_next.min_sum = sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else if (en)
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// File: design/npcm_sqrt_cell.sv
// One bit step of the floor square root of the minimum squared distance.
module npcm_sqrt_cell
    import npcm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic [SUM_W-1:0] step_bit,
    input  sqrt_tok_t        tok_in,
    output sqrt_tok_t        tok_out
);

    sqrt_tok_t      tok_reg;
    sqrt_tok_t      tok_next;
    logic [SUM_W:0] trial;

    always_comb
    begin
        trial    = {1'b0, tok_in.root} + {1'b0, step_bit};
        tok_next = tok_in;
        if ({1'b0, tok_in.rem} >= trial)
        begin
            tok_next.rem  = tok_in.rem - trial[SUM_W-1:0];
            tok_next.root = (tok_in.root >> 1) + step_bit;
        end
        else
        begin
            tok_next.root = tok_in.root >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else if (en)
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// File: design/npcm_pick_cell.sv
// One palette entry of the selection chain: first entry whose sum lies below the bound wins.
module npcm_pick_cell
    import npcm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic [IDX_W-1:0] entry_idx,
    input  pick_tok_t        tok_in,
    output pick_tok_t        tok_out
);

    pick_tok_t tok_reg;
    pick_tok_t tok_next;

    // bound = (dist+1)^2, so a sum below it truncates to the winning distance
    always_comb
    begin
        tok_next = tok_in;
        if (!tok_in.found && (dist_sq(tok_in.pix, entry_idx) < tok_in.bound))
        begin
            tok_next.found = 1'b1;
            tok_next.idx   = entry_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else if (en)
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// File: design/npcm_checker.sv
// Port-level assertions for the palette matcher, bound to the top level.
module npcm_checker
    import npcm_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [IN_DATA_W-1:0]  s_axis_tdata,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic                  cfg_data
);

    logic [23:0] exp_color;

    assign exp_color = RGB_PAL[m_axis_tdata[3:0]];

    // a stalled result transaction stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // input only stalls while a result is waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no pending result");

    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[12:4] <= 9'd441))
        else $error("distance out of range");

    a_color_match: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[20:13] == exp_color[23:16])
                       && (m_axis_tdata[28:21] == exp_color[15:8])
                       && (m_axis_tdata[36:29] == exp_color[7:0]))
        else $error("color fields do not match palette index");

endmodule

bind nearest_palette_color_match npcm_checker u_npcm_checker (.*);

// File: test/testbench.sv
// Self-checking testbench for the nearest palette color matcher.
`timescale 1ns / 100ps

module testbench;
    import npcm_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_LEN    = 300;
    localparam int TAIL_CYCLES = 60;

    typedef struct packed {
        logic [3:0] index;
        logic [8:0] distance;
        logic [7:0] first;
        logic [7:0] second;
        logic [7:0] third;
    } match_t;

    // Palette tables, channels in order first, second, third.
    localparam logic [7:0] RGB_COLORS [16][3] = '{
        '{0, 0, 0}, '{255, 255, 255}, '{58, 102, 22}, '{172, 166, 93},
        '{129, 72, 132}, '{164, 114, 102}, '{64, 50, 134}, '{191, 183, 233},
        '{99, 80, 165}, '{80, 68, 0}, '{105, 150, 70}, '{80, 80, 80},
        '{120, 120, 120}, '{228, 178, 166}, '{120, 106, 189}, '{159, 159, 159}
    };
    localparam logic [7:0] YUV_COLORS [16][3] = '{
        '{0, 0, 0}, '{255, 0, 0}, '{80, 0, 0}, '{159, 0, 11},
        '{96, 18, 29}, '{128, 0, 32}, '{64, 34, 0}, '{191, 21, 0},
        '{96, 34, 3}, '{64, 0, 14}, '{128, 0, 0}, '{80, 0, 0},
        '{120, 0, 0}, '{191, 0, 32}, '{120, 34, 0}, '{159, 0, 0}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // channel_a, channel_b, channel_c
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // palette_index, distance, color_first,
                                                // color_second, color_third, pad
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic                  cfg_data = 1'b0;     // table_select

    match_t      expected_q [$];
    logic        table_sel = SEL_RGB;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          hold_left = 0;
    int          hold_requests = 0;
    int          hold_served = 0;

    nearest_palette_color_match u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic int unsigned floor_sqrt(input int unsigned s);
        int unsigned r;
        r = 0;
        while ((r + 1) * (r + 1) <= s)
            r++;
        return r;
    endfunction

    function automatic logic [7:0] palette_chan(input logic sel, input int k, input int ch);
        return (sel == SEL_RGB) ? RGB_COLORS[k][ch] : YUV_COLORS[k][ch];
    endfunction

    // Nearest entry by truncated distance; trunc_tie flags a tie whose exact sums differ.
    function automatic match_t nearest_entry(input logic [7:0] a, b, c, input logic sel,
                                             output bit trunc_tie);
        logic [7:0]  px [3];
        int unsigned sum, d, best_d, best_sum, diff;
        int          best_k;
        match_t      m;
        px[0] = a;
        px[1] = b;
        px[2] = c;
        best_d = 0;
        best_sum = 0;
        best_k = 0;
        trunc_tie = 1'b0;
        for (int k = 0; k < 16; k++)
        begin
            sum = 0;
            for (int ch = 0; ch < 3; ch++)
            begin
                diff = (palette_chan(sel, k, ch) > px[ch]) ? palette_chan(sel, k, ch) - px[ch]
                                                          : px[ch] - palette_chan(sel, k, ch);
                sum += diff * diff;
            end
            d = floor_sqrt(sum);
            if (k == 0 || d < best_d)
            begin
                best_d = d;
                best_sum = sum;
                best_k = k;
                trunc_tie = 1'b0;
            end
            else if (d == best_d && sum != best_sum)
                trunc_tie = 1'b1;
        end
        m.index    = best_k[3:0];
        m.distance = best_d[8:0];
        m.first    = RGB_COLORS[best_k][0];
        m.second   = RGB_COLORS[best_k][1];
        m.third    = RGB_COLORS[best_k][2];
        return m;
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Long receiver hold-off, started on request from the test sequence.
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_served != hold_requests)
        begin
            hold_served <= hold_requests;
            hold_left <= HOLD_LEN;
        end
    end

    always @(posedge clk)
    begin : result_check
        match_t want, got;
        got = match_t'({m_axis_tdata[3:0], m_axis_tdata[12:4], m_axis_tdata[20:13],
                        m_axis_tdata[28:21], m_axis_tdata[36:29]});
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_q.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result idx=%0d dist=%0d color=%0d/%0d/%0d", $time,
                         got.index, got.distance, got.first, got.second, got.third);
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.index !== want.index || got.distance !== want.distance
                    || got.first !== want.first || got.second !== want.second
                    || got.third !== want.third)
                begin
                    mismatch_count++;
                    $display("%0t: mismatch expected idx=%0d dist=%0d color=%0d/%0d/%0d",
                             $time, want.index, want.distance, want.first, want.second,
                             want.third);
                    $display("%0t:          actual   idx=%0d dist=%0d color=%0d/%0d/%0d",
                             $time, got.index, got.distance, got.first, got.second,
                             got.third);
                end
            end
        end
        m_axis_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic send_pixel(input logic [7:0] a, b, c);
        bit tie;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {c, b, a};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_q.push_back(nearest_entry(a, b, c, table_sel, tie));
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (expected_q.size() != 0);
    endtask

    task automatic write_table_sel(input logic sel);
        cfg_valid <= 1'b1;
        cfg_data <= sel;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        table_sel = sel;
    endtask

    // Looks for a pixel where two entries tie only after the square root is truncated, and sends it if found.
    task automatic send_truncation_tie();
        logic [7:0] a, b, c;
        bit         tie;
        int         n;
        tie = 1'b0;
        for (n = 0; n < 20000 && !tie; n++)
        begin
            a = 8'($urandom);
            b = 8'($urandom);
            c = 8'($urandom);
            void'(nearest_entry(a, b, c, table_sel, tie));
        end
        if (tie)
            send_pixel(a, b, c);
    endtask

    task automatic send_random(input int count);
        int         mode, k, v;
        logic [7:0] px [3];
        repeat (count)
        begin
            mode = $urandom_range(0, 3);
            k = $urandom_range(0, 15);
            for (int ch = 0; ch < 3; ch++)
            begin
                case (mode)
                    2:
                    begin
                        // near a palette entry of the active table
                        v = int'(palette_chan(table_sel, k, ch)) + $urandom_range(0, 16) - 8;
                        if (v < 0)
                            v = 0;
                        if (v > 255)
                            v = 255;
                        px[ch] = v[7:0];
                    end
                    3:
                    begin
                        v = $urandom_range(0, 2);
                        px[ch] = (v == 0) ? 8'd0 : (v == 1) ? 8'd255 : 8'($urandom);
                    end
                    default:
                        px[ch] = 8'($urandom);
                endcase
            end
            send_pixel(px[0], px[1], px[2]);
        end
    endtask

    task automatic test_directed_rgb();
        idle_pct = 0;
        stall_pct <= 0;
        write_table_sel(SEL_RGB);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd191, 8'd183, 8'd233);
        send_pixel(8'd100, 8'd100, 8'd100);    // exact tie between two grays
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'h55, 8'hAA, 8'h55);
        send_pixel(8'hAA, 8'h55, 8'hAA);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_truncation_tie();
        wait_drain();
    endtask

    task automatic test_directed_yuv();
        write_table_sel(SEL_YUV);
        send_pixel(8'd80, 8'd0, 8'd0);         // two identical entries, lower index wins
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd191, 8'd21, 8'd0);
        send_pixel(8'd159, 8'd0, 8'd11);
        send_pixel(8'd96, 8'd18, 8'd29);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd191, 8'd10, 8'd16);
        send_truncation_tie();
        wait_drain();
    endtask

    task automatic test_stream_no_idle();
        idle_pct = 0;
        stall_pct <= 0;
        write_table_sel(SEL_RGB);
        send_random(60);
        wait_drain();
    endtask

    task automatic test_stream_sender_idle();
        idle_pct = 81;
        stall_pct <= 0;
        write_table_sel(SEL_YUV);
        send_random(80);
        wait_drain();
    endtask

    task automatic test_stream_receiver_stall();
        idle_pct = 0;
        stall_pct <= 81;
        write_table_sel(SEL_RGB);
        send_random(80);
        wait_drain();
    endtask

    task automatic test_stream_both_idle();
        idle_pct = 12;
        stall_pct <= 12;
        write_table_sel(SEL_YUV);
        send_random(80);
        wait_drain();
    endtask

    // Receiver holds off long enough that the pipeline fills and input stalls.
    task automatic test_backpressure_hold();
        idle_pct = 0;
        stall_pct <= 0;
        write_table_sel(SEL_RGB);
        hold_requests <= hold_requests + 1;
        send_random(80);
        wait_drain();
        send_random(20);
        wait_drain();
        write_table_sel(SEL_YUV);
        send_random(40);
        wait_drain();
    endtask

    initial
    begin
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_rgb();
        test_directed_yuv();
        test_stream_no_idle();
        test_stream_sender_idle();
        test_stream_receiver_stall();
        test_stream_both_idle();
        test_backpressure_hold();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: nearest_palette_color_match.f
design/npcm_pkg.sv
design/npcm_min_cell.sv
design/npcm_sqrt_cell.sv
design/npcm_pick_cell.sv
design/nearest_palette_color_match.sv
design/npcm_checker.sv
test/testbench.sv
